FILE: hdl/pcbm_pkg.sv
// pcbm_pkg: register indexes, division constants and the per-channel adjust function
// for the pixel contrast / brightness / gray-mask block. No dependencies.
`default_nettype none

package pcbm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CONTRAST   = 3'd0,
        CFG_BRIGHTNESS = 3'd1,
        CFG_OPACITY    = 3'd2,
        CFG_BLACK      = 3'd3,
        CFG_WHITE      = 3'd4
    } cfg_index_t;

    // x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every value this block divides
    localparam int          RECIP_SHIFT  = 24;
    localparam logic [17:0] RECIP_100    = 18'd167773;
    // 255 * RECIP_100, for the brightness offset
    localparam logic [25:0] OFFSET_SCALE = 26'd42782115;

    localparam int GAIN_W   = 27;
    localparam int OFFSET_W = 10;

    localparam logic [8:0]  CONTRAST_RESET = 9'd100;
    localparam logic [7:0]  CENTRE         = 8'd127;

    // contrast stretch about the centre, clamp, brightness offset, clamp again
    function automatic logic [7:0] adjust_channel(
        input logic [7:0]                 chan,
        input logic [GAIN_W-1:0]          gain,
        input logic signed [OFFSET_W-1:0] offset
    );
        logic               below;
        logic [7:0]         delta;
        logic [34:0]        prod;
        logic [9:0]         quot;
        logic signed [11:0] stretched;
        logic [7:0]         stretch_clamped;
        logic signed [10:0] shifted;
        logic [7:0]         result;
        below = chan < CENTRE;
        delta = below ? (CENTRE - chan) : (chan - CENTRE);
        // gain is contrast times the rounded-up 2^24 / 100, so this is a truncating divide
        prod  = 35'(delta) * 35'(gain);
        quot  = prod[33:RECIP_SHIFT];
        if (below)
            stretched = 12'sd127 - $signed({2'b00, quot});
        else
            stretched = 12'sd127 + $signed({2'b00, quot});
        if (stretched < 12'sd0)
            stretch_clamped = 8'd0;
        else if (stretched > 12'sd255)
            stretch_clamped = 8'd255;
        else
            stretch_clamped = stretched[7:0];
        shifted = $signed({3'b000, stretch_clamped}) + $signed({offset[OFFSET_W-1], offset});
        if (shifted < 11'sd0)
            result = 8'd0;
        else if (shifted > 11'sd255)
            result = 8'd255;
        else
            result = shifted[7:0];
        return result;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/pixel_contrast_brightness_mask_top.sv
// pixel_contrast_brightness_mask_top: RGBA pixel contrast, brightness and gray mask.
// Uses pcbm_pkg. A pixel passes the input register, then the result register, before its
// result transfer; throughput one pixel per cycle while out_ready stays high, a held
// result stalls the input once both stages are full. Reset (async, active low) empties
// both stages and loads contrast 100, brightness 0, opacity 255, black 0, white 255.
`default_nettype none

module pixel_contrast_brightness_mask_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pcbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [pcbm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [7:0]                        in_red,
    input  wire logic [7:0]                        in_green,
    input  wire logic [7:0]                        in_blue,
    input  wire logic [7:0]                        in_alpha,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [7:0]                             out_red,
    output logic [7:0]                             out_green,
    output logic [7:0]                             out_blue,
    output logic [7:0]                             out_alpha
);

    // configuration, kept in the form the datapath uses
    logic [pcbm_pkg::GAIN_W-1:0]          gain_reg;
    logic signed [pcbm_pkg::OFFSET_W-1:0] offset_reg;
    logic [7:0]                           opacity_reg;
    logic [7:0]                           black_reg;
    logic [7:0]                           white_reg;

    logic [pcbm_pkg::GAIN_W-1:0]          gain_next;
    logic signed [pcbm_pkg::OFFSET_W-1:0] offset_next;
    logic                                 bright_neg;
    logic [7:0]                           bright_mag;
    logic [33:0]                          bright_prod;
    logic [8:0]                           offset_mag;

    always_comb
    begin
        gain_next   = pcbm_pkg::GAIN_W'(cfg_data) * pcbm_pkg::GAIN_W'(pcbm_pkg::RECIP_100);
        bright_neg  = cfg_data[7];
        bright_mag  = bright_neg ? (8'd0 - cfg_data[7:0]) : cfg_data[7:0];
        bright_prod = 34'(bright_mag) * 34'(pcbm_pkg::OFFSET_SCALE);
        offset_mag  = bright_prod[32:pcbm_pkg::RECIP_SHIFT];
        // truncation toward zero: divide the magnitude, then restore the sign
        offset_next = bright_neg ? -$signed({1'b0, offset_mag}) : $signed({1'b0, offset_mag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= pcbm_pkg::GAIN_W'(pcbm_pkg::CONTRAST_RESET)
                           * pcbm_pkg::GAIN_W'(pcbm_pkg::RECIP_100);
            offset_reg  <= '0;
            opacity_reg <= 8'd255;
            black_reg   <= 8'd0;
            white_reg   <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (pcbm_pkg::cfg_index_t'(cfg_index))
                pcbm_pkg::CFG_CONTRAST:   gain_reg    <= gain_next;
                pcbm_pkg::CFG_BRIGHTNESS: offset_reg  <= offset_next;
                pcbm_pkg::CFG_OPACITY:    opacity_reg <= cfg_data[7:0];
                pcbm_pkg::CFG_BLACK:      black_reg   <= cfg_data[7:0];
                pcbm_pkg::CFG_WHITE:      white_reg   <= cfg_data[7:0];
                default:                  ;
            endcase
        end
    end

    // input register stage
    logic       s1_valid_reg;
    logic [7:0] s1_red_reg;
    logic [7:0] s1_green_reg;
    logic [7:0] s1_blue_reg;
    logic       s1_opaque_reg;
    logic       res_ready;

    assign res_ready = !out_valid || out_ready;
    assign in_ready  = !s1_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_red_reg    <= in_red;
            s1_green_reg  <= in_green;
            s1_blue_reg   <= in_blue;
            s1_opaque_reg <= (in_alpha != 8'd0);
        end
    end

    // datapath between the two registers
    logic [7:0]  red_next;
    logic [7:0]  green_next;
    logic [7:0]  blue_next;
    logic [12:0] gray_sum;
    logic [7:0]  gray;
    logic        masked;
    logic [7:0]  alpha_next;

    always_comb
    begin
        red_next   = pcbm_pkg::adjust_channel(s1_red_reg, gain_reg, offset_reg);
        green_next = pcbm_pkg::adjust_channel(s1_green_reg, gain_reg, offset_reg);
        blue_next  = pcbm_pkg::adjust_channel(s1_blue_reg, gain_reg, offset_reg);
        gray_sum   = 13'(red_next) * 13'd11 + (13'(green_next) << 4) + 13'(blue_next) * 13'd5;
        gray       = gray_sum[12:5];
        masked     = (gray < black_reg) || (gray > white_reg);
        alpha_next = (s1_opaque_reg && !masked) ? opacity_reg : 8'd0;
    end

    // result register
    logic out_valid_reg;
    logic [7:0] out_red_reg;
    logic [7:0] out_green_reg;
    logic [7:0] out_blue_reg;
    logic [7:0] out_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && res_ready)
        begin
            out_red_reg   <= red_next;
            out_green_reg <= green_next;
            out_blue_reg  <= blue_next;
            out_alpha_reg <= alpha_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign out_alpha = out_alpha_reg;

`ifndef SYNTHESIS
    // a pixel in the input stage with the result slot free moves on next cycle
    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && res_ready) |=> out_valid)
        else $error("input stage did not advance into result register");

    // back-pressure only when both stages hold a pixel
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // an input transfer always lands in the input stage
    a_input_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted pixel lost");
`endif

endmodule

`default_nettype wire
